// ----- rtl/uft_pkg.sv -----
`default_nettype none

package uft_pkg;

  // fixed field widths of the ports
  localparam int IN_NODE_W  = 10;
  localparam int OUT_SIZE_W = 11;

  // operation codes carried by in_action
  typedef enum logic {
    ACT_UNION = 1'b0,
    ACT_FIND  = 1'b1
  } act_t;

endpackage

`default_nettype wire

// ----- rtl/uft_ram.sv -----
`default_nettype none

module uft_ram #(
  parameter int DW    = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [DW-1:0]            wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [DW-1:0]            rd
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

// ----- rtl/uft_reduce.sv -----
`default_nettype none

module uft_reduce import uft_pkg::*; #(
  parameter int NODES = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [IN_NODE_W-1:0]     val_a,
  input  wire logic [IN_NODE_W-1:0]     val_b,
  output logic                          done,
  output logic [$clog2(NODES)-1:0]      res_a,
  output logic [$clog2(NODES)-1:0]      res_b
);

  localparam int IW = $clog2(NODES);
  // scaled reciprocal of NODES, rounded up; exact quotient for any index word
  localparam int SH = IN_NODE_W + $clog2(NODES);
  localparam int MW = IN_NODE_W + 2;
  localparam int PW = IN_NODE_W + MW;
  localparam logic [MW-1:0] RECIP = MW'(((2 ** SH) + NODES - 1) / NODES);

  logic                 busy_r;
  logic                 done_r;
  logic [IN_NODE_W-1:0] va_r;
  logic [IN_NODE_W-1:0] vb_r;
  logic [IN_NODE_W-1:0] qa_r;
  logic [IN_NODE_W-1:0] qb_r;
  logic [IN_NODE_W-1:0] rem_a;
  logic [IN_NODE_W-1:0] rem_b;

  function automatic logic [IN_NODE_W-1:0] quot_f(input logic [IN_NODE_W-1:0] v);
    logic [PW-1:0] prod;
    prod = PW'(v) * PW'(RECIP);
    return IN_NODE_W'(prod >> SH);
  endfunction

  // capture, then quotient, then remainder out of the held word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
      if (start) begin
        va_r <= val_a;
        vb_r <= val_b;
      end
      if (busy_r) begin
        qa_r <= quot_f(va_r);
        qb_r <= quot_f(vb_r);
      end
    end
  end

  // remainder fits the index width, so the low bits are enough
  assign rem_a = va_r - IN_NODE_W'(qa_r * NODES);
  assign rem_b = vb_r - IN_NODE_W'(qb_r * NODES);

  assign done  = done_r;
  assign res_a = IW'(rem_a);
  assign res_b = IW'(rem_b);

endmodule

`default_nettype wire

// ----- rtl/union_find_table.sv -----
// Disjoint-set table with union by size and full path compression. After reset the
// block writes every parent link to itself and every set size to one, and takes no
// word until that pass is over. One word is then handled at a time: node indexes are
// first reduced modulo NODES by a reciprocal multiply, then each root walk climbs the
// links on the way up and rewrites each link on the way back, both bound by the single
// read port of the parent memory. A finished result sits in an output register, so the
// next word is taken while it waits to be read; a newer result waits in the last state
// until that register is free.
`default_nettype none

module union_find_table import uft_pkg::*; #(
  parameter int NODES = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_action,
  input  wire logic [IN_NODE_W-1:0]  in_node_a,
  input  wire logic [IN_NODE_W-1:0]  in_node_b,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [IN_NODE_W-1:0]       out_root,
  output logic                       out_joined,
  output logic [OUT_SIZE_W-1:0]      out_group_size
);

  localparam int IW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RED,
    S_P1,
    S_P1D,
    S_P2D,
    S_ROOT,
    S_CA,
    S_CB,
    S_CC,
    S_MERGE,
    S_OUT
  } state_t;

  state_t         state_r;
  logic [IW-1:0]  clr_idx_r;
  act_t           action_r;
  logic [IW-1:0]  nb_r;        // reduced second node, waits for the second walk
  logic [IW-1:0]  cur_r;       // node being climbed in the first pass
  logic [IW-1:0]  start_r;     // where the current walk began
  logic [IW-1:0]  walk_r;      // node being relinked in the second pass
  logic [IW-1:0]  top_r;       // root found by the first pass
  logic           second_r;    // walking node_b's chain
  logic [IW-1:0]  ra_r;
  logic [IW-1:0]  rb_r;
  logic [SW-1:0]  ca_r;
  logic [SW-1:0]  cb_r;
  logic [IW-1:0]  res_root_r;
  logic           res_join_r;
  logic [SW-1:0]  res_size_r;
  logic                   out_valid_r;
  logic [IN_NODE_W-1:0]   out_root_r;
  logic                   out_joined_r;
  logic [OUT_SIZE_W-1:0]  out_size_r;

  // memory ports
  logic           par_we;
  logic [IW-1:0]  par_wa;
  logic [IW-1:0]  par_wd;
  logic [IW-1:0]  par_ra;
  logic [IW-1:0]  par_rd;
  logic           cnt_we;
  logic [IW-1:0]  cnt_wa;
  logic [SW-1:0]  cnt_wd;
  logic [IW-1:0]  cnt_ra;
  logic [SW-1:0]  cnt_rd;

  // index reduction
  logic           red_done;
  logic [IW-1:0]  red_a;
  logic [IW-1:0]  red_b;

  logic           in_acc;
  logic           out_free;
  logic [SW-1:0]  sum;
  logic           a_wins;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // sizes never exceed NODES, so the sum fits
  assign sum      = ca_r + cb_r;
  // equal sizes keep node_a's root
  assign a_wins   = !(ca_r < cb_r);

  uft_reduce #(
    .NODES (NODES)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .val_a (in_node_a),
    .val_b (in_node_b),
    .done  (red_done),
    .res_a (red_a),
    .res_b (red_b)
  );

  uft_ram #(
    .DW    (IW),
    .DEPTH (NODES)
  ) u_parent (
    .clk (clk),
    .we  (par_we),
    .wa  (par_wa),
    .wd  (par_wd),
    .ra  (par_ra),
    .rd  (par_rd)
  );

  uft_ram #(
    .DW    (SW),
    .DEPTH (NODES)
  ) u_count (
    .clk (clk),
    .we  (cnt_we),
    .wa  (cnt_wa),
    .wd  (cnt_wd),
    .ra  (cnt_ra),
    .rd  (cnt_rd)
  );

  // memory address and write steering; every write lands before any later read
  // of the same entry is issued, so no forwarding is needed
  always_comb begin
    par_we = 1'b0;
    par_wa = walk_r;
    par_wd = top_r;
    par_ra = cur_r;
    cnt_we = 1'b0;
    cnt_wa = clr_idx_r;
    cnt_wd = SW'(1);
    cnt_ra = ra_r;
    unique case (state_r)
      S_CLEAR: begin
        // sweep after reset: self links, size one
        par_we = 1'b1;
        par_wa = clr_idx_r;
        par_wd = clr_idx_r;
        cnt_we = 1'b1;
      end
      S_P1D: begin
        // keep climbing, or issue the first read of the relink pass
        par_ra = (par_rd != cur_r) ? par_rd : start_r;
      end
      S_P2D: begin
        // point this node at the root and read the old link in the same cycle
        par_we = 1'b1;
        par_ra = par_rd;
      end
      S_CB: begin
        cnt_ra = rb_r;
      end
      S_MERGE: begin
        // smaller set hangs under the larger root
        par_we = 1'b1;
        cnt_we = 1'b1;
        cnt_wd = sum;
        if (a_wins) begin
          par_wa = rb_r;
          par_wd = ra_r;
          cnt_wa = ra_r;
        end else begin
          par_wa = ra_r;
          par_wd = rb_r;
          cnt_wa = rb_r;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer with the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a result loaded in the output state keeps valid high
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + IW'(1);
          if (clr_idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            action_r <= act_t'(in_action);
            state_r  <= S_RED;
          end
        end
        S_RED: begin
          if (red_done) begin
            cur_r    <= red_a;
            start_r  <= red_a;
            nb_r     <= red_b;
            second_r <= 1'b0;
            state_r  <= S_P1;
          end
        end
        S_P1: begin
          state_r <= S_P1D;
        end
        S_P1D: begin
          if (par_rd != cur_r) begin
            cur_r <= par_rd;
          end else begin
            // root reached
            top_r  <= cur_r;
            walk_r <= start_r;
            state_r <= (start_r == cur_r) ? S_ROOT : S_P2D;
          end
        end
        S_P2D: begin
          walk_r <= par_rd;
          if (par_rd == top_r) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!second_r) begin
            ra_r <= top_r;
            if (action_r == ACT_UNION) begin
              cur_r    <= nb_r;
              start_r  <= nb_r;
              second_r <= 1'b1;
              state_r  <= S_P1;
            end else begin
              state_r <= S_CA;
            end
          end else begin
            rb_r    <= top_r;
            state_r <= S_CA;
          end
        end
        S_CA: begin
          state_r <= S_CB;
        end
        S_CB: begin
          ca_r <= cnt_rd;
          if (action_r == ACT_FIND) begin
            res_root_r <= ra_r;
            res_join_r <= 1'b0;
            res_size_r <= cnt_rd;
            state_r    <= S_OUT;
          end else begin
            state_r <= S_CC;
          end
        end
        S_CC: begin
          cb_r <= cnt_rd;
          if (ra_r == rb_r) begin
            // same set, nothing changes
            res_root_r <= ra_r;
            res_join_r <= 1'b0;
            res_size_r <= ca_r;
            state_r    <= S_OUT;
          end else begin
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          res_root_r <= a_wins ? ra_r : rb_r;
          res_join_r <= 1'b1;
          res_size_r <= sum;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_root_r   <= IN_NODE_W'(res_root_r);
            out_joined_r <= res_join_r;
            out_size_r   <= OUT_SIZE_W'(res_size_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_root       = out_root_r;
  assign out_joined     = out_joined_r;
  assign out_group_size = out_size_r;

  // a result word only appears out of the output state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word without a finished operation");

  // no memory writes while idle or handing off a result
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> (!par_we && !cnt_we))
    else $error("memory write outside an operation");

  // reduced indexes stay inside the table
  a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> ((32'(red_a) < NODES) && (32'(red_b) < NODES)))
    else $error("index reduction out of range");

  // relink write never collides with the read issued alongside it
  a_relink_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2D) |-> (par_wa != par_ra))
    else $error("relink write and read at one entry");

  // a merge only joins distinct roots and reports joined
  a_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (ra_r != rb_r) ##1 (res_join_r && state_r == S_OUT))
    else $error("bad merge sequence");

endmodule

`default_nettype wire
